// ===== design/sac_pkg.sv =====
// Shared types, constants and the arctangent table for the stick axis conditioner.
// No dependencies; every design file imports this package.
package sac_pkg;

  localparam int FRAC_BITS  = 14;
  localparam int AXIS_W     = 16;
  localparam int REG_W      = 15;
  localparam int MAG_W      = 15;
  localparam int ONE        = 1 << FRAC_BITS;
  localparam int DIV_BITS   = 16;
  localparam int REM_W      = 30;
  localparam int SQ_W       = 30;
  localparam int SQR_STEPS  = 15;
  localparam int CW         = 42;
  localparam int ZW         = 36;
  localparam int PRESHIFT   = 24;
  localparam int ATAN_MAX   = 24;
  localparam logic signed [ZW-1:0] PI_Q30 = 36'sd3373259426;

  typedef enum logic {
    REG_FULL_SCALE = 1'b0,
    REG_DEAD_ZONE  = 1'b1
  } sac_reg_e;

  typedef struct packed {
    logic                     opcode;
    logic signed [AXIS_W-1:0] x_in;
    logic signed [AXIS_W-1:0] y_in;
  } sac_in_t;

  typedef struct packed {
    logic signed [AXIS_W-1:0] stick_x;
    logic signed [AXIS_W-1:0] stick_y;
    logic [MAG_W-1:0]         magnitude;
    logic signed [AXIS_W-1:0] angle;
  } sac_out_t;

  // divider chain payload, both axes side by side
  typedef struct packed {
    logic                     opcode;
    logic signed [AXIS_W-1:0] x_raw;
    logic signed [AXIS_W-1:0] y_raw;
    logic                     x_neg;
    logic                     y_neg;
    logic                     x_sat;
    logic                     y_sat;
    logic [REM_W-1:0]         x_rem;
    logic [REM_W-1:0]         y_rem;
    logic [DIV_BITS-1:0]      x_q;
    logic [DIV_BITS-1:0]      y_q;
  } sac_div_t;

  // square root chain payload, carries the conditioned axes along
  typedef struct packed {
    logic [SQ_W-1:0]          n;
    logic [SQ_W-1:0]          res;
    logic signed [AXIS_W-1:0] x;
    logic signed [AXIS_W-1:0] y;
  } sac_sqr_t;

  // vectoring rotator payload
  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
  } sac_cor_t;

  // arctan(2^-i) in Q2.30, truncated
  function automatic logic [31:0] atan_q30(input int unsigned i);
    logic [31:0] v;
    case (i)
      0:       v = 32'd843314856;
      1:       v = 32'd497837829;
      2:       v = 32'd263043836;
      3:       v = 32'd133525158;
      4:       v = 32'd67021686;
      5:       v = 32'd33543515;
      6:       v = 32'd16775850;
      7:       v = 32'd8388437;
      8:       v = 32'd4194282;
      9:       v = 32'd2097149;
      10:      v = 32'd1048575;
      11:      v = 32'd524287;
      12:      v = 32'd262143;
      13:      v = 32'd131071;
      14:      v = 32'd65535;
      15:      v = 32'd32767;
      16:      v = 32'd16383;
      17:      v = 32'd8191;
      18:      v = 32'd4095;
      19:      v = 32'd2047;
      20:      v = 32'd1023;
      21:      v = 32'd511;
      22:      v = 32'd255;
      23:      v = 32'd127;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== design/sac_div_cell.sv =====
// One restoring-division cell: resolves one quotient bit for both axes.
// Depends on sac_pkg.
module sac_div_cell #(
  parameter int BIT = 0
) (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [sac_pkg::REG_W-1:0]  fs_i,
  input  sac_pkg::sac_div_t          in_i,
  output sac_pkg::sac_div_t          out_o
);
  import sac_pkg::*;

  logic [REM_W:0] dvs;
  logic           take_x, take_y;
  sac_div_t       cell_d, cell_q;

  // compare and subtract the shifted divisor
  always_comb begin
    dvs    = (REM_W+1)'(fs_i) << BIT;
    take_x = {1'b0, in_i.x_rem} >= dvs;
    take_y = {1'b0, in_i.y_rem} >= dvs;
    cell_d = in_i;
    if (take_x) begin
      cell_d.x_rem    = REM_W'({1'b0, in_i.x_rem} - dvs);
      cell_d.x_q[BIT] = 1'b1;
    end
    if (take_y) begin
      cell_d.y_rem    = REM_W'({1'b0, in_i.y_rem} - dvs);
      cell_d.y_q[BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) cell_q <= cell_d;
  end

  assign out_o = cell_q;

endmodule

// ===== design/sac_sqr_cell.sv =====
// One digit-by-digit square root cell; steps past the last one only pass data.
// Depends on sac_pkg.
module sac_sqr_cell #(
  parameter int STEP = 0
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  sac_pkg::sac_sqr_t in_i,
  output sac_pkg::sac_sqr_t out_o
);
  import sac_pkg::*;

  localparam bit ACTIVE = STEP < SQR_STEPS;
  localparam int SH     = ACTIVE ? 2 * (SQR_STEPS - 1 - STEP) : 0;

  logic [SQ_W:0] trial;
  logic [SQ_W:0] bitv;
  sac_sqr_t      cell_d, cell_q;

  // try res + bit against the remainder
  always_comb begin
    bitv   = (SQ_W+1)'(1) << SH;
    trial  = {1'b0, in_i.res} + bitv;
    cell_d = in_i;
    if (ACTIVE) begin
      if ({1'b0, in_i.n} >= trial) begin
        cell_d.n   = SQ_W'({1'b0, in_i.n} - trial);
        cell_d.res = SQ_W'({1'b0, in_i.res >> 1} + bitv);
      end else begin
        cell_d.res = in_i.res >> 1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) cell_q <= cell_d;
  end

  assign out_o = cell_q;

endmodule

// ===== design/sac_cor_cell.sv =====
// One vectoring rotator cell; cells past the configured count only pass data.
// Depends on sac_pkg.
module sac_cor_cell #(
  parameter int IDX    = 0,
  parameter int STAGES = 16
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  sac_pkg::sac_cor_t in_i,
  output sac_pkg::sac_cor_t out_o
);
  import sac_pkg::*;

  localparam bit ACTIVE = (IDX < STAGES) && (IDX < ATAN_MAX);
  localparam logic signed [ZW-1:0] ATAN = $signed(ZW'(atan_q30(IDX)));

  logic signed [CW-1:0] xs, ys;
  sac_cor_t             cell_d, cell_q;

  // rotate toward the x axis
  always_comb begin
    xs     = in_i.x >>> IDX;
    ys     = in_i.y >>> IDX;
    cell_d = in_i;
    if (ACTIVE) begin
      if (!in_i.y[CW-1]) begin
        cell_d.x = in_i.x + ys;
        cell_d.y = in_i.y - xs;
        cell_d.z = in_i.z + ATAN;
      end else begin
        cell_d.x = in_i.x - ys;
        cell_d.y = in_i.y + xs;
        cell_d.z = in_i.z - ATAN;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) cell_q <= cell_d;
  end

  assign out_o = cell_q;

endmodule

// ===== design/stick_axis_conditioner_core.sv =====
// Top level of the stick axis conditioner: divider, square root and rotator cell rows.
// Depends on sac_pkg, sac_div_cell, sac_sqr_cell, sac_cor_cell.
//
//   channel | signals                          | direction
//   in      | in_valid_i in_ready_o in_data_i  | sample beat in
//   out     | out_valid_o out_ready_i out_data_o | result beat out
//   cfg     | cfg_we_i cfg_idx_i cfg_wdata_i   | register write
//
// One beat per cycle is accepted unless the output beat waits. Stages: entry, the
// 16-cell divider row, dead zone, squares, longer of square root and rotator rows, result.
// All stages advance together; the whole row holds while the output beat waits.
// Reset clears valid bits and loads register defaults; payload stages are not reset.
module stick_axis_conditioner_core #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  sac_pkg::sac_in_t          in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output sac_pkg::sac_out_t         out_data_o,
  input  logic                      cfg_we_i,
  input  sac_pkg::sac_reg_e         cfg_idx_i,
  input  logic [sac_pkg::REG_W-1:0] cfg_wdata_i
);
  import sac_pkg::*;

  localparam int M   = (CORDIC_STAGES > SQR_STEPS) ? CORDIC_STAGES : SQR_STEPS;
  localparam int LAT = 20 + M;

  logic [REG_W-1:0] fs_q, dz_q, fs_eff;
  logic             en;
  logic [LAT-1:0]   vld_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fs_q <= REG_W'(1000);
      dz_q <= REG_W'(819);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FULL_SCALE: fs_q <= cfg_wdata_i;
        REG_DEAD_ZONE:  dz_q <= cfg_wdata_i;
        default:        fs_q <= fs_q;
      endcase
    end
  end

  assign fs_eff = (fs_q == '0) ? REG_W'(1) : fs_q;

  // advance the whole row unless the output beat is stuck
  assign en         = !vld_q[LAT-1] || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  // entry stage: absolute values, rounded numerators, overflow flags
  logic [AXIS_W:0] ax, ay;
  logic [REM_W-1:0] nx, ny;
  sac_div_t div_d, div_s [0:DIV_BITS];

  always_comb begin
    ax = in_data_i.x_in[AXIS_W-1] ? ((AXIS_W+1)'(0) - {1'b1, in_data_i.x_in})
                                  : {1'b0, in_data_i.x_in};
    ay = in_data_i.y_in[AXIS_W-1] ? ((AXIS_W+1)'(0) - {1'b1, in_data_i.y_in})
                                  : {1'b0, in_data_i.y_in};
    nx = REM_W'({ax, FRAC_BITS'(0)}) + REM_W'(fs_eff >> 1);
    ny = REM_W'({ay, FRAC_BITS'(0)}) + REM_W'(fs_eff >> 1);
    div_d.opcode = in_data_i.opcode;
    div_d.x_raw  = in_data_i.x_in;
    div_d.y_raw  = in_data_i.y_in;
    div_d.x_neg  = in_data_i.x_in[AXIS_W-1];
    div_d.y_neg  = in_data_i.y_in[AXIS_W-1];
    div_d.x_sat  = {1'b0, nx} >= {fs_eff, DIV_BITS'(0)};
    div_d.y_sat  = {1'b0, ny} >= {fs_eff, DIV_BITS'(0)};
    div_d.x_rem  = nx;
    div_d.y_rem  = ny;
    div_d.x_q    = '0;
    div_d.y_q    = '0;
  end

  always_ff @(posedge clk_i) begin
    if (en) div_s[0] <= div_d;
  end

  // divider row, most significant quotient bit first
  for (genvar k = 0; k < DIV_BITS; k++) begin : g_div
    sac_div_cell #(.BIT(DIV_BITS - 1 - k)) u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .fs_i  (fs_eff),
      .in_i  (div_s[k]),
      .out_o (div_s[k+1])
    );
  end

  // normalize and flip y, or take raw axes when opcode is set; clamp; dead zone
  sac_div_t                 dl;
  logic [DIV_BITS-1:0]      qx, qy;
  logic signed [AXIS_W-1:0] cx, cy, ox, oy, ax_c, ay_c;
  logic signed [AXIS_W-1:0] x_q, y_q;

  always_comb begin
    dl = div_s[DIV_BITS];
    qx = (dl.x_sat || dl.x_q > DIV_BITS'(ONE)) ? DIV_BITS'(ONE) : dl.x_q;
    qy = (dl.y_sat || dl.y_q > DIV_BITS'(ONE)) ? DIV_BITS'(ONE) : dl.y_q;
    if (dl.opcode) begin
      cx = (dl.x_raw > AXIS_W'(ONE)) ? AXIS_W'(ONE)
         : (dl.x_raw < -$signed(AXIS_W'(ONE))) ? -$signed(AXIS_W'(ONE)) : dl.x_raw;
      cy = (dl.y_raw > AXIS_W'(ONE)) ? AXIS_W'(ONE)
         : (dl.y_raw < -$signed(AXIS_W'(ONE))) ? -$signed(AXIS_W'(ONE)) : dl.y_raw;
    end else begin
      cx = dl.x_neg ? -$signed(qx) : $signed(qx);
      cy = dl.y_neg ? $signed(qy) : -$signed(qy);
    end
    ax_c = cx[AXIS_W-1] ? -cx : cx;
    ay_c = cy[AXIS_W-1] ? -cy : cy;
    ox   = ({1'b0, ax_c} <= (AXIS_W+1)'(dz_q)) ? '0 : cx;
    oy   = ({1'b0, ay_c} <= (AXIS_W+1)'(dz_q)) ? '0 : cy;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x_q <= ox;
      y_q <= oy;
    end
  end

  // squares for the magnitude, pre-rotation for the angle
  logic signed [2*AXIS_W-1:0] xx, yy;
  logic [SQ_W-2:0]            xx_q, yy_q;
  logic signed [AXIS_W-1:0]   px_q, py_q;
  sac_cor_t                   pre_d;
  sac_sqr_t                   sqr_s [0:M];
  sac_cor_t                   cor_s [0:M];

  always_comb begin
    xx      = x_q * x_q;
    yy      = y_q * y_q;
    pre_d.x = CW'(x_q) <<< PRESHIFT;
    pre_d.y = CW'(y_q) <<< PRESHIFT;
    pre_d.z = '0;
    if (x_q[AXIS_W-1]) begin
      pre_d.z = y_q[AXIS_W-1] ? -PI_Q30 : PI_Q30;
      pre_d.x = -pre_d.x;
      pre_d.y = -pre_d.y;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      xx_q     <= xx[SQ_W-2:0];
      yy_q     <= yy[SQ_W-2:0];
      px_q     <= x_q;
      py_q     <= y_q;
      cor_s[0] <= pre_d;
    end
  end

  always_comb begin
    sqr_s[0].n   = SQ_W'(xx_q) + SQ_W'(yy_q);
    sqr_s[0].res = '0;
    sqr_s[0].x   = px_q;
    sqr_s[0].y   = py_q;
  end

  // square root and rotator rows run side by side
  for (genvar k = 0; k < M; k++) begin : g_row
    sac_sqr_cell #(.STEP(k)) u_sqr (
      .clk_i (clk_i),
      .en_i  (en),
      .in_i  (sqr_s[k]),
      .out_o (sqr_s[k+1])
    );
    sac_cor_cell #(.IDX(k), .STAGES(CORDIC_STAGES)) u_cor (
      .clk_i (clk_i),
      .en_i  (en),
      .in_i  (cor_s[k]),
      .out_o (cor_s[k+1])
    );
  end

  // round and clamp magnitude, scale angle, apply angle dead zone
  sac_sqr_t                 sl;
  logic [SQ_W-1:0]          mag_r;
  logic [MAG_W-1:0]         mag;
  logic signed [ZW-1:0]     zr;
  logic signed [AXIS_W-1:0] ang, ang_abs;
  sac_out_t                 res_d, res_q;

  always_comb begin
    sl      = sqr_s[M];
    mag_r   = sl.res + SQ_W'(sl.n > sl.res);
    mag     = (mag_r > SQ_W'(ONE)) ? MAG_W'(ONE) : mag_r[MAG_W-1:0];
    zr      = (cor_s[M].z + ZW'(65536)) >>> 17;
    ang     = zr[AXIS_W-1:0];
    ang_abs = ang[AXIS_W-1] ? -ang : ang;
    if (mag == '0 || {ang_abs, 1'b0} <= (AXIS_W+1)'(dz_q)) ang = '0;
    res_d.stick_x   = sl.x;
    res_d.stick_y   = sl.y;
    res_d.magnitude = mag;
    res_d.angle     = ang;
  end

  always_ff @(posedge clk_i) begin
    if (en) res_q <= res_d;
  end

  assign out_valid_o = vld_q[LAT-1];
  assign out_data_o  = res_q;

`ifndef SYNTHESIS
  a_mag_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.magnitude <= MAG_W'(ONE))
    else $error("magnitude above one");

  a_angle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.magnitude == '0) |-> out_data_o.angle == '0)
    else $error("angle set with zero magnitude");

  a_axis_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.stick_x <= AXIS_W'(ONE) &&
                     out_data_o.stick_x >= -$signed(AXIS_W'(ONE))))
    else $error("x axis out of range");
`endif

endmodule
